@@ hdl/pfa_pkg.sv @@
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared widths, constants and controller/datapath interface types for the
// power factor accumulator.
// ----------------------------------------------------------------------------
package pfa_pkg;

   localparam int SAMPLE_WIDTH  = 16;
   localparam int PROD_WIDTH    = 2 * SAMPLE_WIDTH;
   localparam int ACC_WIDTH     = 48;
   localparam int HALF_WIDTH    = ACC_WIDTH / 2;
   localparam int W_WIDTH       = 2 * ACC_WIDTH;
   localparam int PF_WIDTH      = 16;
   localparam int M_WIDTH       = 16;
   localparam int BIT_IDX_WIDTH = $clog2(M_WIDTH);
   localparam int T_WIDTH       = W_WIDTH + M_WIDTH;
   localparam int SRCH_WIDTH    = W_WIDTH + 2 * M_WIDTH;
   localparam int R_SHIFT       = 30;
   localparam int MUL_STEPS     = 4;
   localparam int MUL_CNT_WIDTH = $clog2(2 * MUL_STEPS);

   localparam logic [1:0] MUL_STEP_LL = 2'b00;
   localparam logic [1:0] MUL_STEP_HH = 2'b11;

   typedef struct packed {
      logic                     take;
      logic                     clear_acc;
      logic                     mul_clr;
      logic                     mul_en;
      logic                     mul_sel;
      logic [1:0]               mul_step;
      logic                     srch_init;
      logic                     srch_a;
      logic                     srch_b;
      logic [BIT_IDX_WIDTH-1:0] bit_idx;
      logic                     load_out;
      logic                     out_zero;
   } pfa_cmd_type;

   typedef struct packed {
      logic zero_energy;
   } pfa_stat_type;

endpackage

@@ hdl/pfa_datapath.sv @@
// ----------------------------------------------------------------------------
// pfa_datapath
// Sample products, saturating accumulators, shared 24x24 multiplier for the
// energy and product squares, bit-wise root/ratio search and result register.
// ----------------------------------------------------------------------------
module pfa_datapath
   import pfa_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  pfa_cmd_type                cmd,
   output pfa_stat_type               stat,
   input  logic signed [SAMPLE_WIDTH-1:0] voltage_sample,
   input  logic signed [SAMPLE_WIDTH-1:0] current_sample,
   output logic [PF_WIDTH-1:0]        power_factor,
   output logic                       zero_energy
);

   localparam logic signed [ACC_WIDTH:0] SMAX_EXT = {2'b00, {(ACC_WIDTH-1){1'b1}}};
   localparam logic signed [ACC_WIDTH:0] SMIN_EXT = -SMAX_EXT - 1;

   // stage 1: products
   logic signed [PROD_WIDTH-1:0] vc_prod, vv_prod, cc_prod;
   logic signed [PROD_WIDTH:0]   nvc_in, nvc_ff;
   logic [PROD_WIDTH-2:0]        vv_in, vv_ff, cc_in, cc_ff;
   logic                         s1_valid_ff;

   // accumulators
   logic signed [ACC_WIDTH-1:0] psum_ff, psum_in;
   logic [ACC_WIDTH-1:0]        ven_ff, ven_in, cen_ff, cen_in;
   logic signed [ACC_WIDTH:0]   psum_sum;
   logic [ACC_WIDTH:0]          ven_sum, cen_sum;

   // multiplier
   logic [ACC_WIDTH-1:0]  abs_p, mul_a, mul_b;
   logic [HALF_WIDTH-1:0] a_half, b_half;
   logic [ACC_WIDTH-1:0]  pp_ff, pp_in;
   logic                  pp_valid_ff, pp_sel_ff;
   logic [1:0]            pp_step_ff;
   logic [W_WIDTH-1:0]    pp_shifted;
   logic [W_WIDTH-1:0]    w_ff, w_in, r_ff, r_in;

   // search
   logic [SRCH_WIDTH-1:0] s_ff, s_in, cand_ff, cand_in, r_scaled;
   logic [T_WIDTH-1:0]    t_ff, t_in;
   logic [M_WIDTH-1:0]    m_ff, m_in;
   logic                  fit;

   // result
   logic                  neg;
   logic [M_WIDTH:0]      mag_raw, cap, mag;
   logic [PF_WIDTH-1:0]   pf_ff, pf_in;
   logic                  zero_ff, zero_in;

   assign vc_prod = voltage_sample * current_sample;
   assign vv_prod = voltage_sample * voltage_sample;
   assign cc_prod = current_sample * current_sample;
   assign nvc_in  = (PROD_WIDTH+1)'(0) - (PROD_WIDTH+1)'(vc_prod);
   assign vv_in   = vv_prod[PROD_WIDTH-2:0];
   assign cc_in   = cc_prod[PROD_WIDTH-2:0];

   assign psum_sum = (ACC_WIDTH+1)'(psum_ff) + (ACC_WIDTH+1)'(nvc_ff);
   assign ven_sum  = (ACC_WIDTH+1)'(ven_ff) + (ACC_WIDTH+1)'(vv_ff);
   assign cen_sum  = (ACC_WIDTH+1)'(cen_ff) + (ACC_WIDTH+1)'(cc_ff);

   always_comb begin
      psum_in = psum_ff;
      ven_in  = ven_ff;
      cen_in  = cen_ff;
      if (cmd.clear_acc) begin
         psum_in = '0;
         ven_in  = '0;
         cen_in  = '0;
      end else if (s1_valid_ff) begin
         if (psum_sum > SMAX_EXT) begin
            psum_in = SMAX_EXT[ACC_WIDTH-1:0];
         end else if (psum_sum < SMIN_EXT) begin
            psum_in = SMIN_EXT[ACC_WIDTH-1:0];
         end else begin
            psum_in = psum_sum[ACC_WIDTH-1:0];
         end
         ven_in = ven_sum[ACC_WIDTH] ? '1 : ven_sum[ACC_WIDTH-1:0];
         cen_in = cen_sum[ACC_WIDTH] ? '1 : cen_sum[ACC_WIDTH-1:0];
      end
   end

   assign stat.zero_energy = (ven_ff == '0) || (cen_ff == '0);

   // 48x48 products as four 24x24 partial products
   assign abs_p  = psum_ff[ACC_WIDTH-1] ? ACC_WIDTH'(-psum_ff) : ACC_WIDTH'(psum_ff);
   assign mul_a  = cmd.mul_sel ? abs_p : ven_ff;
   assign mul_b  = cmd.mul_sel ? abs_p : cen_ff;
   assign a_half = cmd.mul_step[1] ? mul_a[ACC_WIDTH-1:HALF_WIDTH] : mul_a[HALF_WIDTH-1:0];
   assign b_half = cmd.mul_step[0] ? mul_b[ACC_WIDTH-1:HALF_WIDTH] : mul_b[HALF_WIDTH-1:0];
   assign pp_in  = ACC_WIDTH'(a_half) * ACC_WIDTH'(b_half);

   always_comb begin
      case (pp_step_ff)
         MUL_STEP_LL: pp_shifted = W_WIDTH'(pp_ff);
         MUL_STEP_HH: pp_shifted = W_WIDTH'(pp_ff) << (2 * HALF_WIDTH);
         default:     pp_shifted = W_WIDTH'(pp_ff) << HALF_WIDTH;
      endcase
   end

   always_comb begin
      w_in = w_ff;
      r_in = r_ff;
      if (cmd.mul_clr) begin
         w_in = '0;
         r_in = '0;
      end else if (pp_valid_ff) begin
         if (pp_sel_ff) begin
            r_in = r_ff + pp_shifted;
         end else begin
            w_in = w_ff + pp_shifted;
         end
      end
   end

   // one result bit per pass: S = m*m*W, T = m*W
   assign cand_in  = s_ff + ((SRCH_WIDTH'(t_ff) << cmd.bit_idx) << 1)
                   + (SRCH_WIDTH'(w_ff) << {cmd.bit_idx, 1'b0});
   assign r_scaled = SRCH_WIDTH'(r_ff) << R_SHIFT;
   assign fit      = cand_ff <= r_scaled;

   always_comb begin
      s_in = s_ff;
      t_in = t_ff;
      m_in = m_ff;
      if (cmd.srch_init) begin
         s_in = '0;
         t_in = '0;
         m_in = '0;
      end else if (cmd.srch_b && fit) begin
         s_in = cand_ff;
         t_in = t_ff + (T_WIDTH'(w_ff) << cmd.bit_idx);
         m_in[cmd.bit_idx] = 1'b1;
      end
   end

   // Q1.15 result, capped at 32767 / -32768
   assign neg     = psum_ff[ACC_WIDTH-1];
   assign mag_raw = (M_WIDTH+1)'(m_ff);
   assign cap     = neg ? (M_WIDTH+1)'(1 << (PF_WIDTH-1)) : (M_WIDTH+1)'((1 << (PF_WIDTH-1)) - 1);
   assign mag     = (mag_raw > cap) ? cap : mag_raw;

   always_comb begin
      pf_in   = pf_ff;
      zero_in = zero_ff;
      if (cmd.load_out) begin
         zero_in = cmd.out_zero;
         if (cmd.out_zero) begin
            pf_in = '0;
         end else if (neg) begin
            pf_in = PF_WIDTH'((M_WIDTH+1)'(0) - mag);
         end else begin
            pf_in = PF_WIDTH'(mag);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         pp_valid_ff <= 1'b0;
         psum_ff     <= '0;
         ven_ff      <= '0;
         cen_ff      <= '0;
      end else begin
         s1_valid_ff <= cmd.take;
         pp_valid_ff <= cmd.mul_en;
         psum_ff     <= psum_in;
         ven_ff      <= ven_in;
         cen_ff      <= cen_in;
      end
   end

   always_ff @(posedge clock) begin
      nvc_ff     <= nvc_in;
      vv_ff      <= vv_in;
      cc_ff      <= cc_in;
      pp_ff      <= pp_in;
      pp_sel_ff  <= cmd.mul_sel;
      pp_step_ff <= cmd.mul_step;
      w_ff       <= w_in;
      r_ff       <= r_in;
      s_ff       <= s_in;
      t_ff       <= t_in;
      m_ff       <= m_in;
      pf_ff      <= pf_in;
      zero_ff    <= zero_in;
      if (cmd.srch_a) begin
         cand_ff <= cand_in;
      end
   end

   assign power_factor = pf_ff;
   assign zero_energy  = zero_ff;

endmodule

@@ hdl/pfa_ctrl.sv @@
// ----------------------------------------------------------------------------
// pfa_ctrl
// Sequencer: sample intake, accumulator drain, multiply steps, result bit
// search and result register hand-off.
// ----------------------------------------------------------------------------
module pfa_ctrl
   import pfa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  pfa_stat_type stat,
   output pfa_cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_ACCUM,
      S_DRAIN,
      S_CHECK,
      S_MUL,
      S_MUL_DRAIN,
      S_SRCH_A,
      S_SRCH_B,
      S_FINISH
   } state_type;

   state_type                state_ff, state_in;
   logic [MUL_CNT_WIDTH-1:0] step_ff, step_in;
   logic [BIT_IDX_WIDTH-1:0] bit_ff, bit_in;
   logic                     zero_ff, zero_in;
   logic                     rsp_tvalid_ff, rsp_tvalid_in;
   logic                     out_free;

   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = (state_ff == S_ACCUM);
   assign rsp_tvalid = rsp_tvalid_ff;

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      bit_in        = bit_ff;
      zero_in       = zero_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      cmd           = '0;
      cmd.mul_sel   = step_ff[MUL_CNT_WIDTH-1];
      cmd.mul_step  = step_ff[1:0];
      cmd.bit_idx   = bit_ff;
      cmd.out_zero  = zero_ff;
      case (state_ff)
         S_ACCUM: begin
            cmd.take = req_tvalid;
            if (req_tvalid && req_tlast) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd.mul_clr = 1'b1;
            zero_in     = stat.zero_energy;
            step_in     = '0;
            state_in    = stat.zero_energy ? S_FINISH : S_MUL;
         end
         S_MUL: begin
            cmd.mul_en = 1'b1;
            step_in    = step_ff + 1'b1;
            if (step_ff == '1) begin
               state_in = S_MUL_DRAIN;
            end
         end
         S_MUL_DRAIN: begin
            cmd.srch_init = 1'b1;
            bit_in        = '1;
            state_in      = S_SRCH_A;
         end
         S_SRCH_A: begin
            cmd.srch_a = 1'b1;
            state_in   = S_SRCH_B;
         end
         S_SRCH_B: begin
            cmd.srch_b = 1'b1;
            bit_in     = bit_ff - 1'b1;
            state_in   = (bit_ff == '0) ? S_FINISH : S_SRCH_A;
         end
         S_FINISH: begin
            if (out_free) begin
               cmd.load_out  = 1'b1;
               cmd.clear_acc = 1'b1;
               rsp_tvalid_in = 1'b1;
               state_in      = S_ACCUM;
            end
         end
         default: begin
            state_in = S_ACCUM;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_ACCUM;
         step_ff       <= '0;
         bit_ff        <= '0;
         zero_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         bit_ff        <= bit_in;
         zero_ff       <= zero_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_tvalid_ff || rsp_tready))
      else $error("result register loaded while a transfer is pending");

   a_search_seq: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SRCH_B) |=> (state_ff == S_SRCH_A || state_ff == S_FINISH))
      else $error("search pass left out of sequence");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff == S_FINISH))
      else $error("result raised outside finish");

   a_no_intake_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL || state_ff == S_SRCH_A || state_ff == S_SRCH_B) |-> !cmd.take)
      else $error("sample taken during computation");

endmodule

@@ hdl/power_factor_accumulator.sv @@
// ----------------------------------------------------------------------------
// power_factor_accumulator
// Power factor of a run of signed voltage/current sample pairs.
// ----------------------------------------------------------------------------
// Sample pairs are taken one per clock until the pair marked by tlast. That
// pair then starts the result computation, during which no pair is taken:
// req_tready stays low until the result is loaded into the output register,
// and longer if an earlier result is still waiting there. The work is done
// by one shared 24x24 multiplier (eight partial products for the two 96-bit
// squares), skipped when either channel energy is zero, and by the 16-bit
// result search, one bit per pass over a 128-bit add and compare. A finished
// result waits in an output register, so the next run may start while it has
// not been taken yet. Result is signed Q1.15, saturated to -32768..32767;
// tuser flags a zero energy, with tdata then forced to zero.
// ----------------------------------------------------------------------------
module power_factor_accumulator
   import pfa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] voltage_sample, [31:16] current_sample
   input  logic        req_tlast,   // last_sample
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] power_factor
   output logic [0:0]  rsp_tuser    // [0] zero_energy
);

   pfa_cmd_type  cmd;
   pfa_stat_type stat;
   logic         zero_energy;

   pfa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   pfa_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .voltage_sample (signed'(req_tdata[SAMPLE_WIDTH-1:0])),
      .current_sample (signed'(req_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH])),
      .power_factor   (rsp_tdata),
      .zero_energy    (zero_energy)
   );

   assign rsp_tuser[0] = zero_energy;

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for power_factor_accumulator. Sample pairs go in as
// stream transfers, with a directed table first and then random runs of
// varied shape. A local model of the three accumulators and the Q1.15 root
// and divide predicts results the table does not give; every result is checked
// field by field, in order. Both channels idle at random, in three phases.
// ----------------------------------------------------------------------------
module tb_top
   import pfa_pkg::*;
;

   localparam longint ACC_SMAX = (64'sd1 <<< (ACC_WIDTH - 1)) - 1;
   localparam longint ACC_SMIN = -ACC_SMAX - 1;
   localparam longint unsigned ACC_UMAX = (64'd1 << ACC_WIDTH) - 1;
   localparam int RANDOM_PAIRS = 1080;
   localparam int DRAIN_CYCLES = 60;
   localparam int N_DIRECTED = 23;

   typedef struct packed {
      logic signed [PF_WIDTH-1:0] pf;
      logic                       zero_energy;
   } pf_result_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] volt;
      logic signed [SAMPLE_WIDTH-1:0] curr;
      logic                           last;
      logic [19:0]                    reps;
      logic                           typed;
      logic signed [PF_WIDTH-1:0]     pf;
      logic                           zero_energy;
   } pair_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [0:0]  rsp_tuser;

   always #10 clock = ~clock;

   power_factor_accumulator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // volt, curr, last, repeat count, typed, power factor, zero energy
   pair_row_type directed_rows [0:N_DIRECTED-1] = '{
      '{16'sd0,      16'sd0,      1'b1, 20'd1, 1'b1, 16'sd0,      1'b1},
      '{16'sd32767,  16'sd0,      1'b1, 20'd1, 1'b1, 16'sd0,      1'b1},
      '{16'sd0,     -16'sd32768,  1'b1, 20'd1, 1'b1, 16'sd0,      1'b1},
      '{16'sd5,      16'sd0,      1'b0, 20'd1, 1'b0, 16'sd0,      1'b0},
      '{-16'sd7,     16'sd0,      1'b0, 20'd1, 1'b0, 16'sd0,      1'b0},
      '{16'sd0,      16'sd0,      1'b1, 20'd1, 1'b1, 16'sd0,      1'b1},
      '{-16'sd32768, -16'sd32768, 1'b1, 20'd1, 1'b1, -16'sd32768, 1'b0},
      '{16'sd32767,  -16'sd32767, 1'b1, 20'd1, 1'b1, 16'sd32767,  1'b0},
      '{16'sd32767,  16'sd32767,  1'b1, 20'd1, 1'b1, -16'sd32768, 1'b0},
      '{-16'sd32768, 16'sd32767,  1'b1, 20'd1, 1'b1, 16'sd32767,  1'b0},
      '{16'sd1,      16'sd1,      1'b1, 20'd1, 1'b1, -16'sd32768, 1'b0},
      '{16'sd1,      -16'sd1,     1'b1, 20'd1, 1'b1, 16'sd32767,  1'b0},
      '{16'sd1,      16'sd0,      1'b0, 20'd1, 1'b0, 16'sd0,      1'b0},
      '{16'sd0,      16'sd1,      1'b1, 20'd1, 1'b1, 16'sd0,      1'b0},
      '{16'sd2,      -16'sd1,     1'b0, 20'd1, 1'b0, 16'sd0,      1'b0},
      '{-16'sd1,     16'sd2,      1'b1, 20'd1, 1'b0, 16'sd0,      1'b0},
      '{16'sd100,    16'sd200,    1'b0, 20'd1, 1'b0, 16'sd0,      1'b0},
      '{-16'sd300,   16'sd50,     1'b0, 20'd1, 1'b0, 16'sd0,      1'b0},
      '{16'sd7,      -16'sd9,     1'b1, 20'd1, 1'b0, 16'sd0,      1'b0},
      '{16'sh5555,   16'shAAAA,   1'b1, 20'd1, 1'b0, 16'sd0,      1'b0},
      '{16'shAAAA,   16'sh5555,   1'b1, 20'd1, 1'b0, 16'sd0,      1'b0},
      // full-scale run of many pairs in anti-phase
      '{-16'sd32768, 16'sd32767,  1'b1, 20'd40, 1'b0, 16'sd0,     1'b0},
      '{16'sd12345,  -16'sd23456, 1'b1, 20'd1, 1'b0, 16'sd0,      1'b0}
   };

   longint          pwr_acc = 0;
   longint unsigned vsq_acc = 0;
   longint unsigned isq_acc = 0;

   pf_result_type expected_pf_q [$];

   int fail_count = 0;
   int pairs_sent = 0;
   int runs_sent = 0;
   int results_seen = 0;
   int zero_results = 0;
   int capped_results = 0;
   int snd_idle_pct = 0;
   int rcv_idle_pct = 0;

   function automatic void add_pair(input logic signed [SAMPLE_WIDTH-1:0] volt,
                                    input logic signed [SAMPLE_WIDTH-1:0] curr);
      longint v;
      longint c;
      longint unsigned vv;
      longint unsigned cc;
      v = volt;
      c = curr;
      vv = v * v;
      cc = c * c;
      pwr_acc = pwr_acc - v * c;
      if (pwr_acc > ACC_SMAX) pwr_acc = ACC_SMAX;
      if (pwr_acc < ACC_SMIN) pwr_acc = ACC_SMIN;
      vsq_acc = (ACC_UMAX - vsq_acc < vv) ? ACC_UMAX : vsq_acc + vv;
      isq_acc = (ACC_UMAX - isq_acc < cc) ? ACC_UMAX : isq_acc + cc;
   endfunction

   // largest m with m^2 * V * I <= P^2 * 2^30, sign of P, then clear
   function automatic pf_result_type close_run();
      pf_result_type res;
      logic [127:0] mag;
      logic [127:0] rhs;
      logic [127:0] vi;
      logic [127:0] msq;
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      res = '0;
      if (vsq_acc == 0 || isq_acc == 0) begin
         res.zero_energy = 1'b1;
      end else begin
         mag = (pwr_acc < 0) ? 128'(-pwr_acc) : 128'(pwr_acc);
         rhs = (mag * mag) << R_SHIFT;
         vi = 128'(vsq_acc) * 128'(isq_acc);
         lo = 0;
         hi = (pwr_acc < 0) ? 32768 : 32767;
         while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            msq = 128'(mid) * 128'(mid);
            if (msq * vi <= rhs) lo = mid;
            else hi = mid - 1;
         end
         res.pf = PF_WIDTH'(lo);
         if (pwr_acc < 0) res.pf = -res.pf;
      end
      pwr_acc = 0;
      vsq_acc = 0;
      isq_acc = 0;
      return res;
   endfunction

   task automatic send_pair(input logic signed [SAMPLE_WIDTH-1:0] volt,
                            input logic signed [SAMPLE_WIDTH-1:0] curr,
                            input bit last, input bit typed, input pf_result_type typed_res);
      pf_result_type res;
      while ($urandom_range(99) < snd_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {curr, volt};
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      pairs_sent++;
      add_pair(volt, curr);
      if (last) begin
         res = close_run();
         if (typed) res = typed_res;
         expected_pf_q.push_back(res);
         runs_sent++;
      end
      @(negedge clock);
   endtask

   function automatic logic signed [SAMPLE_WIDTH-1:0] extreme_code();
      case ($urandom_range(5))
         0: return -16'sd32768;
         1: return -16'sd32767;
         2: return -16'sd1;
         3: return 16'sd0;
         4: return 16'sd1;
         default: return 16'sd32767;
      endcase
   endfunction

   task automatic send_random_run();
      int shape;
      int len;
      int style;
      int shift;
      bit flip;
      bit side;
      logic signed [SAMPLE_WIDTH-1:0] volt;
      logic signed [SAMPLE_WIDTH-1:0] curr;
      shape = $urandom_range(99);
      len = (shape < 40) ? $urandom_range(1, 4) :
            (shape < 85) ? $urandom_range(5, 16) : $urandom_range(17, 64);
      style = $urandom_range(9);
      shift = $urandom_range(3);
      flip = 1'($urandom_range(1));
      side = 1'($urandom_range(1));
      for (int i = 0; i < len; i++) begin
         volt = SAMPLE_WIDTH'($urandom);
         curr = SAMPLE_WIDTH'($urandom);
         case (style)
            3, 4: begin
               // nearly in phase or in anti-phase, power factor near full scale
               curr = volt >>> shift;
               if (flip) curr = -curr;
               curr = curr + SAMPLE_WIDTH'($urandom_range(6) - 3);
            end
            5: begin
               volt = SAMPLE_WIDTH'($urandom_range(6) - 3);
               curr = SAMPLE_WIDTH'($urandom_range(6) - 3);
            end
            6: begin
               if (side) volt = '0;
               else curr = '0;
            end
            7: begin
               volt = extreme_code();
               curr = extreme_code();
            end
            8: curr = SAMPLE_WIDTH'($urandom_range(6) - 3);
            default: ;
         endcase
         send_pair(volt, curr, i == len - 1, 1'b0, '0);
      end
   endtask

   always @(negedge clock) rsp_tready <= ($urandom_range(99) >= rcv_idle_pct);

   always @(posedge clock) begin : rsp_check
      pf_result_type exp_res;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_pf_q.size() == 0) begin
            $error("unexpected result transfer: power_factor %0d, zero_energy %0b",
                   $signed(rsp_tdata), rsp_tuser[0]);
            fail_count++;
         end else begin
            exp_res = expected_pf_q.pop_front();
            results_seen++;
            if (rsp_tuser[0]) zero_results++;
            if (rsp_tdata == 16'h7FFF || rsp_tdata == 16'h8000) capped_results++;
            if (rsp_tdata !== exp_res.pf) begin
               $error("power_factor: expected %0d, actual %0d",
                      exp_res.pf, $signed(rsp_tdata));
               fail_count++;
            end
            if (rsp_tuser[0] !== exp_res.zero_energy) begin
               $error("zero_energy: expected %0b, actual %0b",
                      exp_res.zero_energy, rsp_tuser[0]);
               fail_count++;
            end
         end
      end
   end

   initial begin
      int first_random;
      pf_result_type typed_res;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      snd_idle_pct = 28;
      rcv_idle_pct = 83;
      foreach (directed_rows[r]) begin
         typed_res.pf = directed_rows[r].pf;
         typed_res.zero_energy = directed_rows[r].zero_energy;
         for (int n = 1; n <= directed_rows[r].reps; n++)
            send_pair(directed_rows[r].volt, directed_rows[r].curr,
                      directed_rows[r].last && n == directed_rows[r].reps,
                      directed_rows[r].typed, typed_res);
      end
      first_random = pairs_sent;
      while (pairs_sent - first_random < RANDOM_PAIRS) begin
         if (pairs_sent - first_random >= 2 * RANDOM_PAIRS / 3) begin
            snd_idle_pct = 0;
            rcv_idle_pct = 0;
         end else if (pairs_sent - first_random >= RANDOM_PAIRS / 3) begin
            snd_idle_pct = 83;
            rcv_idle_pct = 28;
         end
         send_random_run();
      end
      req_tvalid <= 1'b0;
      req_tlast <= 1'b0;
      while (expected_pf_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_pf_q.size() != 0) begin
         $error("%0d expected results never arrived", expected_pf_q.size());
         fail_count++;
      end
      $display("Run covered %0d sample pairs in %0d runs, %0d results checked,",
               pairs_sent, runs_sent, results_seen);
      $display("of which %0d flagged zero energy and %0d sat at full scale.",
               zero_results, capped_results);
      if (fail_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $error("timeout");
      $display("tb_top NOT OK");
      $finish;
   end

endmodule
